// File: rtl/core/dsa_pkg.sv
// dsa_pkg: shared types and constants for the slot allocator
// no dependencies
`default_nettype none
package dsa_pkg;
  localparam int SLOTS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int KEY_W = 32;
  localparam int CNT_W = SLOT_W + 1;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_EXISTING = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_TICK     = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;

  // item passed from the front queue to the back end
  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [2:0]        status;
    logic [KEY_W-1:0]  key_out;
    logic [CNT_W-1:0]  freed_count;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/core/dedup_slot_allocator_deferred_free.sv
// throughput: one item at a time; the back end scans one slot a cycle
// a two-entry queue takes new items while the back end is busy
// reset: synchronous active low; clears maps, hint, frame count, defer to 3; keys read zero
// top level: front queue and back-end sequencer; depends on dsa_pkg, dsa_front, dsa_back
`default_nettype none
module dedup_slot_allocator_deferred_free (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_key,
  input  wire logic [5:0]  in_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_slot_out,
  output logic [2:0]       out_status,
  output logic [31:0]      out_key_out,
  output logic [6:0]       out_freed_count
);
  logic [7:0]    defer_r;
  dsa_pkg::cmd_t in_cmd, q_cmd;
  dsa_pkg::res_t res;
  logic          q_valid, q_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      defer_r <= 8'd3;
    end else if (cfg_we) begin
      defer_r <= cfg_wdata;
    end
  end

  assign in_cmd = '{in_op, in_key, in_slot};

  dsa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  dsa_back u_back (
    .clk, .rst_n, .cfg_defer(defer_r), .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_slot_out    = res.slot_out;
  assign out_status      = res.status;
  assign out_key_out     = res.key_out;
  assign out_freed_count = res.freed_count;
endmodule
`default_nettype wire

// File: rtl/core/dsa_front.sv
// dsa_front: input stage and two-entry command queue
// depends on dsa_pkg
`default_nettype none
module dsa_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dsa_pkg::cmd_t       in_cmd,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output dsa_pkg::cmd_t            q_cmd
);
  dsa_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // pointer and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/dsa_back.sv
// dsa_back: slot table and scanning sequencer, one slot a cycle
// depends on dsa_pkg
`default_nettype none
module dsa_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           cfg_defer,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire dsa_pkg::cmd_t        q_cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dsa_pkg::res_t             out_res
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MATCH = 6'b000010,
    S_FREE  = 6'b000100,
    S_TICK  = 6'b001000,
    S_ONE   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int SW = dsa_pkg::SLOT_W;
  localparam int KW = dsa_pkg::KEY_W;
  localparam int CW = dsa_pkg::CNT_W;

  state_t            st_r;
  dsa_pkg::cmd_t     cmd_r;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     hint_r;
  logic [CW-1:0]     newhint_r;
  logic [CW-1:0]     freed_r;
  logic [31:0]       frame_r;
  logic [dsa_pkg::SLOTS-1:0] alloc_r, park_r;
  logic [KW-1:0]     keys_r  [dsa_pkg::SLOTS];
  logic [31:0]       stamp_r [dsa_pkg::SLOTS];
  logic [KW-1:0]     key_rd_r;
  logic [31:0]       stamp_rd_r;
  logic [SW-1:0]     rd_addr;
  logic [SW-1:0]     cur;
  logic [31:0]       age;
  logic              live;

  assign cur     = idx_r[SW-1:0];
  assign q_ready = (st_r == S_IDLE) && !out_valid;
  assign age     = frame_r - stamp_rd_r;
  // a slot's key only counts while it is allocated and not parked, else it reads as zero
  assign live    = alloc_r[cmd_r.slot] && !park_r[cmd_r.slot];

  // read address: the slot the next cycle works on
  always_comb begin
    case (st_r)
      S_IDLE: begin
        if (q_cmd.op == dsa_pkg::OP_RELEASE || q_cmd.op == dsa_pkg::OP_READ) begin
          rd_addr = q_cmd.slot;
        end else begin
          rd_addr = '0;
        end
      end
      S_MATCH, S_TICK: rd_addr = cur + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  // registered reads of key and stamp tables
  always_ff @(posedge clk) begin
    key_rd_r   <= keys_r[rd_addr];
    stamp_rd_r <= stamp_r[rd_addr];
  end

  // sequencer: match scan, free scan, tick sweep, single-slot ops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      alloc_r   <= '0;
      park_r    <= '0;
      hint_r    <= '0;
      frame_r   <= '0;
      idx_r     <= '0;
      freed_r   <= '0;
      newhint_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd_r   <= q_cmd;
            idx_r   <= '0;
            freed_r <= '0;
            case (q_cmd.op)
              dsa_pkg::OP_CREATE: st_r <= S_MATCH;
              dsa_pkg::OP_TICK: begin
                frame_r   <= frame_r + 32'd1;
                newhint_r <= hint_r;
                st_r      <= S_TICK;
              end
              default: st_r <= S_ONE;
            endcase
          end
        end
        S_MATCH: begin
          if (alloc_r[cur] && !park_r[cur] && key_rd_r == cmd_r.key) begin
            out_res <= '{cur, dsa_pkg::ST_EXISTING, cmd_r.key, '0};
            st_r    <= S_DONE;
          end else if (idx_r == CW'(dsa_pkg::SLOTS - 1)) begin
            idx_r <= hint_r;
            st_r  <= S_FREE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_FREE: begin
          if (idx_r >= CW'(dsa_pkg::SLOTS)) begin
            out_res <= '{'0, dsa_pkg::ST_FULL, '0, '0};
            st_r    <= S_DONE;
          end else if (!alloc_r[cur]) begin
            alloc_r[cur] <= 1'b1;
            keys_r[cur]  <= cmd_r.key;
            hint_r       <= idx_r + 1'b1;
            out_res      <= '{cur, dsa_pkg::ST_NEW, cmd_r.key, '0};
            st_r         <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TICK: begin
          if (park_r[cur] && age >= {24'd0, cfg_defer}) begin
            park_r[cur]  <= 1'b0;
            alloc_r[cur] <= 1'b0;
            freed_r      <= freed_r + 1'b1;
            if (idx_r < newhint_r) newhint_r <= idx_r;
          end
          if (idx_r == CW'(dsa_pkg::SLOTS - 1)) begin
            // last slot folded in here so the result sees it
            if (park_r[cur] && age >= {24'd0, cfg_defer}) begin
              out_res <= '{'0, dsa_pkg::ST_TICK, '0, freed_r + 1'b1};
              hint_r  <= (idx_r < newhint_r) ? idx_r : newhint_r;
            end else begin
              out_res <= '{'0, dsa_pkg::ST_TICK, '0, freed_r};
              hint_r  <= newhint_r;
            end
            st_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_ONE: begin
          if (cmd_r.op == dsa_pkg::OP_RELEASE) begin
            if (!live) begin
              out_res <= '{cmd_r.slot, dsa_pkg::ST_IGNORED, '0, '0};
            end else begin
              park_r[cmd_r.slot]  <= 1'b1;
              stamp_r[cmd_r.slot] <= frame_r;
              out_res <= '{cmd_r.slot, dsa_pkg::ST_RELEASED, '0, '0};
            end
          end else begin
            out_res <= '{cmd_r.slot, dsa_pkg::ST_READ, live ? key_rd_r : '0, '0};
          end
          st_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          st_r      <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/dsa_checker.sv
// dsa_checker: port-level assertions for the slot allocator
// depends on dsa_pkg and dedup_slot_allocator_deferred_free ports
`default_nettype none
module dsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_slot_out,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_key_out,
  input wire logic [6:0]  out_freed_count
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  // tick results carry zero slot and key
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dsa_pkg::ST_TICK |-> out_slot_out == 6'd0 &&
      out_key_out == 32'd0)
    else $error("tick payload");
  // only ticks report freed slots
  a_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dsa_pkg::ST_TICK |-> out_freed_count == 7'd0)
    else $error("freed count");
  // status within range
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= dsa_pkg::ST_READ)
    else $error("bad status");
endmodule

bind dedup_slot_allocator_deferred_free dsa_checker u_chk (.*);
`default_nettype wire
